// ===== rtl/tmc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmc_pkg: shared constants and functions of the model-matrix composer
// Fixed-point widths, rounding and saturation helpers.
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned QuatW   = 18;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned ProdW   = 64;

    localparam logic [CfgIdxW-1:0] CFG_PIVOT_X = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PIVOT_Y = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PIVOT_Z = 2'd2;

    localparam logic signed [DataW-1:0] ONE_Q16 = 32'sd65536;

    // Round half up to Q16.16: floor(v / 2^16 + 1/2).
    function automatic logic signed [47:0] rnd16(input logic signed [ProdW-1:0] v);
        logic signed [ProdW-1:0] s;
        begin
            s = v + 64'sd32768;
            rnd16 = s[63:16];
        end
    endfunction

    function automatic logic signed [DataW-1:0] sat32(input logic signed [49:0] v);
        begin
            if (v > 50'sd2147483647) begin
                sat32 = 32'sh7fffffff;
            end else if (v < -50'sd2147483648) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

endpackage

// ===== rtl/tmc_rot.sv =====
// ----------------------------------------------------------------------------
// tmc_rot: rotation matrix builder
// Two-stage pipeline: quaternion products, then the nine rounded R entries.
// ----------------------------------------------------------------------------
module tmc_rot (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [17:0]       qw,
    input  logic signed [17:0]       qx,
    input  logic signed [17:0]       qy,
    input  logic signed [17:0]       qz,
    output logic signed [33:0]       rq [9]
);
    logic signed [35:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [35:0] xw_reg, yw_reg, zw_reg;
    logic signed [33:0] rq_reg [9];
    logic signed [33:0] rq_next [9];

    function automatic logic signed [33:0] rd(input logic signed [38:0] v);
        logic signed [63:0] e;
        logic signed [47:0] r;
        begin
            e = 64'(v);
            r = tmc_pkg::rnd16(e);
            rd = r[33:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            xz_reg <= qx * qz;
            yz_reg <= qy * qz;
            xw_reg <= qx * qw;
            yw_reg <= qy * qw;
            zw_reg <= qz * qw;
            rq_reg <= rq_next;
        end
    end

    always_comb begin
        // index = row*3 + col
        rq_next[0] = rd(39'sh100000000 - 39'((39'(yy_reg) + 39'(zz_reg)) <<< 1));
        rq_next[3] = rd(39'((39'(xy_reg) - 39'(zw_reg)) <<< 1));
        rq_next[6] = rd(39'((39'(xz_reg) + 39'(yw_reg)) <<< 1));
        rq_next[1] = rd(39'((39'(xy_reg) + 39'(zw_reg)) <<< 1));
        rq_next[4] = rd(39'sh100000000 - 39'((39'(xx_reg) + 39'(zz_reg)) <<< 1));
        rq_next[7] = rd(39'((39'(yz_reg) - 39'(xw_reg)) <<< 1));
        rq_next[2] = rd(39'((39'(xz_reg) - 39'(yw_reg)) <<< 1));
        rq_next[5] = rd(39'((39'(yz_reg) + 39'(xw_reg)) <<< 1));
        rq_next[8] = rd(39'sh100000000 - 39'((39'(xx_reg) + 39'(yy_reg)) <<< 1));
    end

    assign rq = rq_reg;

endmodule

// ===== rtl/trs_model_matrix_compose_core.sv =====
// ----------------------------------------------------------------------------
// trs_model_matrix_compose_core: TRS model matrix composer
// Builds T(pos)*S(scale)*R(quat)*T(-pivot) in Q16.16 and streams four columns.
// ----------------------------------------------------------------------------
//  Channel | Handshake        | Word
//  s_      | s_valid/s_ready  | pos, scale, quaternion
//  m_      | m_valid/m_ready  | one matrix column, column 0 first
//  cfg     | cfg_we           | pivot x/y/z by cfg_index
//
// Each input word passes a six-stage pipeline: quaternion products, rounded
// R entries, scale products, saturated M, M*pivot products, then the sum and
// saturation of the translation column. The output register emits the four
// columns of one matrix, one per accepted transfer, and loads the next only
// when its last column is taken; the single result channel sets the rate.
// The whole pipeline advances only when its last stage is empty or being
// handed over, so a stall on the result side holds every stage and nothing
// is lost or repeated. Reset clears the valid bits and the pivot registers.
module trs_model_matrix_compose_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_pos_z,
    input  logic signed [31:0]   s_scale_x,
    input  logic signed [31:0]   s_scale_y,
    input  logic signed [31:0]   s_scale_z,
    input  logic signed [17:0]   s_quat_w,
    input  logic signed [17:0]   s_quat_x,
    input  logic signed [17:0]   s_quat_y,
    input  logic signed [17:0]   s_quat_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_column_index,
    output logic signed [31:0]   m_elem_row0,
    output logic signed [31:0]   m_elem_row1,
    output logic signed [31:0]   m_elem_row2,
    output logic signed [31:0]   m_elem_row3,
    output logic                 m_last_column
);
    localparam int Stages = 6;

    logic signed [31:0] pivot_reg [3];
    logic [Stages-1:0]  vld_reg;
    logic               adv;
    logic               out_busy_reg;
    logic [1:0]         col_reg;
    logic               load;

    // Pos and scale travel along with the pipeline.
    logic signed [31:0] pos_reg [Stages-1][3];
    logic signed [31:0] scl_reg [2][3];

    logic signed [33:0] rq [9];
    logic signed [65:0] sp_reg [9];
    logic signed [31:0] m_reg [9];
    logic signed [31:0] m2_reg [9];
    logic signed [63:0] mp_reg [9];
    logic signed [31:0] mo_reg [9];
    logic signed [31:0] t_reg [3];

    // Pivot registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) pivot_reg[i] <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tmc_pkg::CFG_PIVOT_X: pivot_reg[0] <= cfg_data;
                tmc_pkg::CFG_PIVOT_Y: pivot_reg[1] <= cfg_data;
                tmc_pkg::CFG_PIVOT_Z: pivot_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // The output register takes a new matrix when empty or when its last column is taken.
    assign load = !out_busy_reg || (m_ready && col_reg == 2'd3);
    assign adv  = !vld_reg[Stages-1] || load;
    assign s_ready = adv;

    tmc_rot u_rot (
        .aclk (aclk),
        .en   (adv),
        .qw   (s_quat_w),
        .qx   (s_quat_x),
        .qy   (s_quat_y),
        .qz   (s_quat_z),
        .rq   (rq)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[Stages-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos_reg[0][0] <= s_pos_x;
            pos_reg[0][1] <= s_pos_y;
            pos_reg[0][2] <= s_pos_z;
            scl_reg[0][0] <= s_scale_x;
            scl_reg[0][1] <= s_scale_y;
            scl_reg[0][2] <= s_scale_z;
            scl_reg[1]    <= scl_reg[0];
            for (int s = 1; s < Stages - 1; s++) pos_reg[s] <= pos_reg[s-1];
            for (int i = 0; i < 9; i++) begin
                // stage 3: scale times R
                sp_reg[i] <= scl_reg[1][i/3] * rq[i];
                // stage 4: round and saturate M
                m_reg[i]  <= tmc_pkg::sat32(50'(tmc_pkg::rnd16(sp_reg[i][63:0])));
                // stage 5: M times pivot
                mp_reg[i] <= m_reg[i] * pivot_reg[i%3];
                m2_reg[i] <= m_reg[i];
                mo_reg[i] <= m2_reg[i];
            end
            // stage 6: translation column
            for (int r = 0; r < 3; r++) begin
                t_reg[r] <= tmc_pkg::sat32(50'(pos_reg[4][r])
                    - 50'(tmc_pkg::rnd16(mp_reg[3*r]))
                    - 50'(tmc_pkg::rnd16(mp_reg[3*r+1]))
                    - 50'(tmc_pkg::rnd16(mp_reg[3*r+2])));
            end
        end
    end

    // Output column sequencer.
    logic signed [31:0] om_reg [9];
    logic signed [31:0] ot_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_busy_reg <= 1'b0;
            col_reg      <= '0;
        end else if (load) begin
            out_busy_reg <= vld_reg[Stages-1];
            col_reg      <= '0;
        end else if (m_ready) begin
            col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            om_reg <= mo_reg;
            ot_reg <= t_reg;
        end
    end

    assign m_valid        = out_busy_reg;
    assign m_column_index = col_reg;
    assign m_last_column  = (col_reg == 2'd3);
    assign m_elem_row0    = (col_reg == 2'd3) ? ot_reg[0] : om_reg[{2'b00, col_reg}];
    assign m_elem_row1    = (col_reg == 2'd3) ? ot_reg[1] : om_reg[4'd3 + {2'b00, col_reg}];
    assign m_elem_row2    = (col_reg == 2'd3) ? ot_reg[2] : om_reg[4'd6 + {2'b00, col_reg}];
    assign m_elem_row3    = (col_reg == 2'd3) ? tmc_pkg::ONE_Q16 : '0;

endmodule
